### design/lge_pkg.sv
// Shared constants, types and the B3/S23 rule for the Life generation engine.
package lge_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;
  localparam int CFG_W        = 7;
  localparam int CFG_IDX_W    = 1;
  localparam int COUNT_W      = 13;
  localparam int OP_W         = 2;
  localparam int IDX_W        = 6;
  localparam int MIN_SIZE     = 3;
  localparam int BIRTH_N      = 3;
  localparam int SURVIVE_N    = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ    = 2'd1;
  localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

  // outcome of one cell update
  typedef struct packed {
    logic nxt;
    logic born;
    logic died;
  } cell_upd_t;

  function automatic logic life_rule(input logic old, input logic [3:0] n);
    life_rule = old ? (n == 4'(SURVIVE_N) || n == 4'(BIRTH_N)) : (n == 4'(BIRTH_N));
  endfunction

endpackage

### design/life_generation_engine.sv
// Top level: command sequencer, counters and result registers around the row store.
//
//  channel   direction  handshake        payload
//  command   in         start / busy     opcode, row_index, col_index, write_alive
//  result    out        done (1 cycle)   read_alive, live_total, addr_invalid
//  config    in         cfg_we           cfg_index, cfg_data
//
// Read and write do a row read, then modify and write back; a bad address or
// unused opcode is answered at once. Advance loads the last row, row 0 and
// row 1, then one cell a cycle through the window, plus row write and shift.
// After reset a clearing pass writes MAX_ROWS rows, one a cycle, with busy high.
// The receiver cannot stall: done is high for exactly one cycle per command.
module life_generation_engine import lge_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [OP_W-1:0]      opcode,
  input  logic [IDX_W-1:0]     row_index,
  input  logic [IDX_W-1:0]     col_index,
  input  logic                 write_alive,
  output logic                 done,
  output logic                 read_alive,
  output logic [COUNT_W-1:0]   live_total,
  output logic                 addr_invalid,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int RIW  = $clog2(MAX_ROWS);
  localparam int CIW  = $clog2(MAX_COLS);
  localparam int RSW  = $clog2(MAX_ROWS + 1);
  localparam int CSW  = $clog2(MAX_COLS + 1);
  localparam int SZA  = (RSW > CFG_W) ? RSW : CFG_W;
  localparam int SZW  = (CSW > SZA) ? CSW : SZA;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_RMW   = 4'd2;
  localparam logic [3:0] ST_LOAD0 = 4'd3;
  localparam logic [3:0] ST_LOAD1 = 4'd4;
  localparam logic [3:0] ST_LOAD2 = 4'd5;
  localparam logic [3:0] ST_COL   = 4'd6;
  localparam logic [3:0] ST_WRITE = 4'd7;
  localparam logic [3:0] ST_SHIFT = 4'd8;

  logic [3:0]          state;
  logic [CFG_W-1:0]    grid_rows;
  logic [CFG_W-1:0]    grid_cols;
  logic [COUNT_W-1:0]  live_count;
  logic [OP_W-1:0]     op_q;
  logic [RIW-1:0]      row_q;
  logic [CIW-1:0]      col_q;
  logic                wv_q;
  logic [RIW-1:0]      r;
  logic [CIW-1:0]      c;
  logic [MAX_COLS-1:0] up_row;
  logic [MAX_COLS-1:0] cur_row;
  logic [MAX_COLS-1:0] down_row;
  logic [MAX_COLS-1:0] row0_save;
  logic [MAX_COLS-1:0] new_row;

  logic [SZW-1:0]      rows;
  logic [SZW-1:0]      cols;
  logic [RIW-1:0]      last_row;
  logic [CIW-1:0]      last_col;
  logic [SZW-1:0]      r_plus2;
  logic                addr_ok;
  logic                accept;
  cell_upd_t           upd;

  logic                mem_we;
  logic [RIW-1:0]      mem_waddr;
  logic [MAX_COLS-1:0] mem_wdata;
  logic [RIW-1:0]      mem_raddr;
  logic [MAX_COLS-1:0] mem_rdata;

  // saturate the configured size to the range in use
  always_comb begin
    rows = (SZW'(grid_rows) < SZW'(MIN_SIZE)) ? SZW'(MIN_SIZE) :
           (SZW'(grid_rows) > SZW'(MAX_ROWS)) ? SZW'(MAX_ROWS) : SZW'(grid_rows);
    cols = (SZW'(grid_cols) < SZW'(MIN_SIZE)) ? SZW'(MIN_SIZE) :
           (SZW'(grid_cols) > SZW'(MAX_COLS)) ? SZW'(MAX_COLS) : SZW'(grid_cols);
  end

  assign last_row = RIW'(rows - SZW'(1));
  assign last_col = CIW'(cols - SZW'(1));
  assign r_plus2  = SZW'(r) + SZW'(2);
  assign addr_ok  = (SZW'(row_index) < rows) && (SZW'(col_index) < cols);
  assign accept   = start && !busy;
  assign busy     = (state != ST_IDLE);
  assign live_total = live_count;

  lge_row_ram #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lge_window #(.MAX_COLS(MAX_COLS)) u_window (
    .up       (up_row),
    .cur      (cur_row),
    .down     (down_row),
    .col      (c),
    .last_col (last_col),
    .upd      (upd)
  );

  // store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = r;
    mem_wdata = new_row;
    mem_raddr = RIW'(r_plus2);
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        mem_raddr = (opcode == OP_ADVANCE) ? last_row : RIW'(row_index);
      end
      ST_RMW: begin
        mem_we          = (op_q == OP_WRITE);
        mem_waddr       = row_q;
        mem_wdata       = mem_rdata;
        mem_wdata[col_q] = wv_q;
      end
      ST_LOAD0: mem_raddr = '0;
      ST_LOAD1: mem_raddr = RIW'(1);
      ST_WRITE: mem_we = 1'b1;
      default: begin
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= CFG_RESET;
      grid_cols <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS: grid_rows <= cfg_data;
        CFG_COLS: grid_cols <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer, live count and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      r            <= '0;
      c            <= '0;
      live_count   <= '0;
      done         <= 1'b0;
      read_alive   <= 1'b0;
      addr_invalid <= 1'b0;
    end else begin
      done         <= 1'b0;
      read_alive   <= 1'b0;
      addr_invalid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          r <= r + RIW'(1);
          if (r == RIW'(MAX_ROWS - 1)) begin
            r     <= '0;
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            op_q  <= opcode;
            row_q <= RIW'(row_index);
            col_q <= CIW'(col_index);
            wv_q  <= write_alive;
            if (opcode == OP_ADVANCE) begin
              state <= ST_LOAD0;
            end else if ((opcode == OP_WRITE || opcode == OP_READ) && addr_ok) begin
              state <= ST_RMW;
            end else begin
              // bad address or unused opcode: answer at once
              done         <= 1'b1;
              addr_invalid <= (opcode == OP_WRITE || opcode == OP_READ);
            end
          end
        end
        ST_RMW: begin
          if (op_q == OP_WRITE) begin
            if (mem_rdata[col_q] && !wv_q) live_count <= live_count - COUNT_W'(1);
            if (!mem_rdata[col_q] && wv_q) live_count <= live_count + COUNT_W'(1);
          end else begin
            read_alive <= mem_rdata[col_q];
          end
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        ST_LOAD0: begin
          up_row <= mem_rdata;
          state  <= ST_LOAD1;
        end
        ST_LOAD1: begin
          cur_row   <= mem_rdata;
          row0_save <= mem_rdata;
          new_row   <= mem_rdata;
          state     <= ST_LOAD2;
        end
        ST_LOAD2: begin
          down_row <= mem_rdata;
          r        <= '0;
          c        <= '0;
          state    <= ST_COL;
        end
        ST_COL: begin
          new_row[c] <= upd.nxt;
          if (upd.born) live_count <= live_count + COUNT_W'(1);
          if (upd.died) live_count <= live_count - COUNT_W'(1);
          c <= c + CIW'(1);
          if (c == last_col) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (r == last_row) begin
            done  <= 1'b1;
            r     <= '0;
            state <= ST_IDLE;
          end else begin
            state <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          // slide the window one row down, wrap to the saved first row
          up_row   <= cur_row;
          cur_row  <= down_row;
          new_row  <= down_row;
          down_row <= (r_plus2 == rows) ? row0_save : mem_rdata;
          r        <= r + RIW'(1);
          c        <= '0;
          state    <= ST_COL;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_rmw_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RMW) |=> done)
    else $error("read or write finished without a result");
  a_read_only_on_done: assert property (@(posedge clk) disable iff (rst)
    read_alive |-> (done && !addr_invalid))
    else $error("read value outside a good read result");
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (busy && mem_we))
    else $error("clearing pass not writing");

endmodule

### design/lge_row_ram.sv
// Row-wide cell store: one write port, one registered read port.
module lge_row_ram import lge_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [$clog2(MAX_ROWS)-1:0] waddr,
  input  logic [MAX_COLS-1:0]         wdata,
  input  logic [$clog2(MAX_ROWS)-1:0] raddr,
  output logic [MAX_COLS-1:0]         rdata
);

  logic [MAX_COLS-1:0] mem [MAX_ROWS];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### design/lge_window.sv
// 3x3 neighbourhood around one column of three held rows, with column wrap.
module lge_window import lge_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic [MAX_COLS-1:0]         up,
  input  logic [MAX_COLS-1:0]         cur,
  input  logic [MAX_COLS-1:0]         down,
  input  logic [$clog2(MAX_COLS)-1:0] col,
  input  logic [$clog2(MAX_COLS)-1:0] last_col,
  output cell_upd_t                   upd
);

  localparam int CIW = $clog2(MAX_COLS);

  logic [CIW-1:0] left;
  logic [CIW-1:0] right;
  logic [3:0]     n;
  logic           old;

  // wrap column neighbours at the size in use
  assign left  = (col == '0) ? last_col : col - CIW'(1);
  assign right = (col == last_col) ? '0 : col + CIW'(1);

  // count live neighbours and apply the rule
  always_comb begin
    n = 4'(up[left]) + 4'(up[col]) + 4'(up[right])
      + 4'(cur[left]) + 4'(cur[right])
      + 4'(down[left]) + 4'(down[col]) + 4'(down[right]);
    old      = cur[col];
    upd.nxt  = life_rule(old, n);
    upd.born = !old && upd.nxt;
    upd.died = old && !upd.nxt;
  end

endmodule

### bench/tb_life_generation_engine.sv
// Testbench for the toroidal B3/S23 Life engine: directed and random commands against a predictor.
module tb_life_generation_engine;
  import lge_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int GRID_CELLS = DEF_MAX_ROWS * DEF_MAX_COLS;
  localparam int IDLE_LIMIT = 40000;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic               read_alive;
    logic [COUNT_W-1:0] live_total;
    logic               addr_invalid;
  } life_result_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [OP_W-1:0]      opcode;
  logic [IDX_W-1:0]     row_index;
  logic [IDX_W-1:0]     col_index;
  logic                 write_alive;
  logic                 done;
  logic                 read_alive;
  logic [COUNT_W-1:0]   live_total;
  logic                 addr_invalid;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // predicted engine state
  logic         life_cells [GRID_CELLS];
  int unsigned  live_cells;
  logic [CFG_W-1:0] rows_reg;
  logic [CFG_W-1:0] cols_reg;

  life_result_t awaited_results [$];
  int unsigned  mismatches;
  int unsigned  quiet_cycles;
  int           burst_left;

  life_generation_engine dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned size_in_use(input logic [CFG_W-1:0] v, input int maxv);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // compute the next generation of the part in use, all cells at once
  function automatic void step_generation();
    logic        old_cells [GRID_CELLS];
    int unsigned nr, nc, up, dn, lf, rt, n;
    logic        cur, nxt;
    nr = size_in_use(rows_reg, DEF_MAX_ROWS);
    nc = size_in_use(cols_reg, DEF_MAX_COLS);
    old_cells = life_cells;
    for (int unsigned r = 0; r < nr; r++) begin
      up = (r == 0) ? nr - 1 : r - 1;
      dn = (r + 1 == nr) ? 0 : r + 1;
      for (int unsigned c = 0; c < nc; c++) begin
        lf = (c == 0) ? nc - 1 : c - 1;
        rt = (c + 1 == nc) ? 0 : c + 1;
        n = old_cells[up*DEF_MAX_COLS+lf] + old_cells[up*DEF_MAX_COLS+c]
          + old_cells[up*DEF_MAX_COLS+rt] + old_cells[r*DEF_MAX_COLS+lf]
          + old_cells[r*DEF_MAX_COLS+rt] + old_cells[dn*DEF_MAX_COLS+lf]
          + old_cells[dn*DEF_MAX_COLS+c] + old_cells[dn*DEF_MAX_COLS+rt];
        cur = old_cells[r*DEF_MAX_COLS+c];
        nxt = cur ? (n == SURVIVE_N || n == BIRTH_N) : (n == BIRTH_N);
        if (cur && !nxt) live_cells--;
        if (!cur && nxt) live_cells++;
        life_cells[r*DEF_MAX_COLS+c] = nxt;
      end
    end
  endfunction

  // work out the result of one accepted command
  function automatic life_result_t predict_command(input logic [OP_W-1:0] op,
      input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c, input logic w);
    life_result_t res;
    int unsigned  idx;
    res = '0;
    if (op == OP_WRITE || op == OP_READ) begin
      res.addr_invalid = (r >= size_in_use(rows_reg, DEF_MAX_ROWS)) ||
                         (c >= size_in_use(cols_reg, DEF_MAX_COLS));
      if (!res.addr_invalid) begin
        idx = r * DEF_MAX_COLS + c;
        if (op == OP_WRITE) begin
          if (life_cells[idx] && !w) live_cells--;
          if (!life_cells[idx] && w) live_cells++;
          life_cells[idx] = w;
        end else begin
          res.read_alive = life_cells[idx];
        end
      end
    end else if (op == OP_ADVANCE) begin
      step_generation();
    end
    res.live_total = COUNT_W'(live_cells);
    return res;
  endfunction

  // present one command and hold it until the engine takes it
  task automatic issue_command(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] r,
      input logic [IDX_W-1:0] c, input logic w);
    opcode      <= op;
    row_index   <= r;
    col_index   <= c;
    write_alive <= w;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
    awaited_results.push_back(predict_command(op, r, c, w));
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // drop start and wait for every outstanding transaction to complete
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ROWS) rows_reg = v;
    else cols_reg = v;
    @(posedge clk);
  endtask

  task automatic set_grid_size(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c);
    drain_results();
    write_register(CFG_ROWS, r);
    write_register(CFG_COLS, c);
  endtask

  // random burst and gap pattern for the sender
  task automatic maybe_gap();
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 8);
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
    end
    burst_left--;
  endtask

  task automatic test_after_reset();
    issue_command(OP_READ, 6'd0, 6'd0, 1'b0);
    issue_command(OP_READ, 6'd63, 6'd63, 1'b1);
    issue_command(OP_UNUSED, 6'd63, 6'd0, 1'b1);
    issue_command(OP_WRITE, 6'd63, 6'd63, 1'b1);
    issue_command(OP_READ, 6'd63, 6'd63, 1'b0);
  endtask

  task automatic test_blinker_wrap();
    // clamped to 3 rows, 5 columns: blinker straddling the wrap edge
    set_grid_size(7'd0, 7'd5);
    issue_command(OP_WRITE, 6'd0, 6'd4, 1'b1);
    issue_command(OP_WRITE, 6'd1, 6'd4, 1'b1);
    issue_command(OP_WRITE, 6'd2, 6'd4, 1'b1);
    issue_command(OP_WRITE, 6'd2, 6'd4, 1'b1);
    issue_command(OP_WRITE, 6'd3, 6'd0, 1'b1);
    issue_command(OP_READ, 6'd0, 6'd5, 1'b0);
    issue_command(OP_ADVANCE, 6'd0, 6'd0, 1'b0);
    issue_command(OP_READ, 6'd1, 6'd0, 1'b0);
    issue_command(OP_ADVANCE, 6'd63, 6'd63, 1'b1);
    issue_command(OP_WRITE, 6'd1, 6'd4, 1'b0);
    issue_command(OP_UNUSED, 6'd0, 6'd0, 1'b0);
  endtask

  task automatic test_shrunk_grid();
    // cells beyond a shrunk size keep counting but stay out of reach
    set_grid_size(7'd127, 7'd64);
    issue_command(OP_WRITE, 6'd40, 6'd40, 1'b1);
    issue_command(OP_WRITE, 6'd0, 6'd0, 1'b1);
    set_grid_size(7'd3, 7'd127);
    issue_command(OP_READ, 6'd40, 6'd40, 1'b0);
    issue_command(OP_WRITE, 6'd2, 6'd63, 1'b1);
    issue_command(OP_WRITE, 6'd1, 6'd63, 1'b1);
    issue_command(OP_ADVANCE, 6'd0, 6'd0, 1'b0);
    issue_command(OP_READ, 6'd2, 6'd0, 1'b0);
  endtask

  task automatic test_random_phase(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c,
      input int items, input int advance_pct);
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] ri, ci;
    int unsigned      nr, nc, pick;
    set_grid_size(r, c);
    nr = size_in_use(rows_reg, DEF_MAX_ROWS);
    nc = size_in_use(cols_reg, DEF_MAX_COLS);
    burst_left = 0;
    repeat (items) begin
      maybe_gap();
      pick = $urandom_range(0, 99);
      if (pick < advance_pct) op = OP_ADVANCE;
      else if (pick < advance_pct + 3) op = OP_UNUSED;
      else if (pick < 70) op = OP_WRITE;
      else op = OP_READ;
      // mostly in range, sometimes anywhere in the field
      if ($urandom_range(0, 9) == 0) begin
        ri = IDX_W'($urandom_range(0, 63));
        ci = IDX_W'($urandom_range(0, 63));
      end else begin
        ri = IDX_W'($urandom_range(0, nr - 1));
        ci = IDX_W'($urandom_range(0, nc - 1));
      end
      issue_command(op, ri, ci, $urandom_range(0, 2) != 0);
    end
  endtask

  // compare each result against the oldest prediction
  always @(posedge clk) begin
    life_result_t want;
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("unexpected result: read_alive=%0b live_total=%0d addr_invalid=%0b",
                   read_alive, live_total, addr_invalid);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (want.read_alive !== read_alive || want.live_total !== live_total ||
            want.addr_invalid !== addr_invalid) begin
          if (mismatches < REPORT_MAX)
            $display("mismatch: want read_alive=%0b live_total=%0d addr_invalid=%0b, got %0b %0d %0b",
                     want.read_alive, want.live_total, want.addr_invalid,
                     read_alive, live_total, addr_invalid);
          mismatches++;
        end
      end
    end
  end

  // abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    opcode = OP_WRITE;
    row_index = '0;
    col_index = '0;
    write_alive = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ROWS;
    cfg_data = '0;
    mismatches = 0;
    quiet_cycles = 0;
    for (int i = 0; i < GRID_CELLS; i++) life_cells[i] = 1'b0;
    live_cells = 0;
    rows_reg = CFG_RESET;
    cols_reg = CFG_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_after_reset();
    test_blinker_wrap();
    test_shrunk_grid();
    test_random_phase(7'd8, 7'd8, 25, 15);
    test_random_phase(7'd5, 7'd11, 25, 15);
    test_random_phase(7'd127, 7'd4, 15, 10);
    test_random_phase(7'd3, 7'd3, 15, 20);
    test_random_phase(CFG_W'($urandom_range(3, 16)), CFG_W'($urandom_range(3, 16)), 25, 12);
    test_random_phase(7'd64, 7'd64, 12, 10);

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### sim.f
design/lge_pkg.sv
design/lge_row_ram.sv
design/lge_window.sv
design/life_generation_engine.sv
bench/tb_life_generation_engine.sv
